// ===== hw/rtl/beq_pkg.sv =====
`default_nettype none
package beq_pkg;

	localparam int NUM_BANDS_DEF  = 3;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 28;
	localparam int EXT_BITS       = 16;
	localparam int PROD_SHIFT     = 8;
	localparam int OUT_SHIFT      = COEF_FRAC_BITS - PROD_SHIFT;
	localparam int MEM_BITS       = 48;
	localparam int GOAL_BITS      = 32;
	localparam int CUR_BITS       = GOAL_BITS + EXT_BITS;
	localparam int PROD_BITS      = GOAL_BITS + SAMPLE_BITS;
	localparam int PSH_BITS       = PROD_BITS - PROD_SHIFT;
	localparam int ACC_BITS       = MEM_BITS + 2;
	localparam int RND_BITS       = ACC_BITS + 1;
	localparam int YSH_BITS       = RND_BITS - OUT_SHIFT;
	localparam int DIFF_BITS      = CUR_BITS + 1;
	localparam int NCOEF          = 5;
	localparam int CI_BITS        = 3;
	localparam int MODE_BITS      = 3;
	localparam int BAND_BITS      = 2;
	localparam int RL_BITS        = 12;
	localparam int RL_RESET       = 480;

	localparam logic [MODE_BITS-1:0] MODE_SAMPLE = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_STAGE  = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_COMMIT = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_FLAT   = 3'd4;

	localparam logic [CI_BITS-1:0] CI_B0   = 3'd0;
	localparam logic [CI_BITS-1:0] CI_LAST = 3'd4;

	localparam logic signed [GOAL_BITS-1:0] GOAL_ONE = GOAL_BITS'(64'd1 << COEF_FRAC_BITS);
	localparam logic signed [CUR_BITS-1:0]  CUR_ONE  =
		CUR_BITS'(64'd1 << (COEF_FRAC_BITS + EXT_BITS));

	function automatic logic signed [MEM_BITS-1:0] sat_mem(input logic signed [ACC_BITS-1:0] v);
		logic signed [MEM_BITS-1:0] r;
		if (v[ACC_BITS-1:MEM_BITS-1] == '0 || v[ACC_BITS-1:MEM_BITS-1] == '1)
			r = v[MEM_BITS-1:0];
		else if (v[ACC_BITS-1])
			r = {1'b1, {(MEM_BITS-1){1'b0}}};
		else
			r = {1'b0, {(MEM_BITS-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
		input logic signed [YSH_BITS-1:0] v);
		logic signed [SAMPLE_BITS-1:0] r;
		if (v[YSH_BITS-1:SAMPLE_BITS-1] == '0 || v[YSH_BITS-1:SAMPLE_BITS-1] == '1)
			r = v[SAMPLE_BITS-1:0];
		else if (v[YSH_BITS-1])
			r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/beq_mul.sv =====
`default_nettype none
module beq_mul import beq_pkg::*; (
	input  wire                               clk,
	input  wire  logic signed [GOAL_BITS-1:0]   a,
	input  wire  logic signed [SAMPLE_BITS-1:0] b,
	output logic signed [PROD_BITS-1:0]        p
);

	always_ff @(posedge clk) begin
		p <= PROD_BITS'(a) * PROD_BITS'(b);
	end

endmodule
`default_nettype wire

// ===== hw/rtl/beq_div.sv =====
`default_nettype none
module beq_div import beq_pkg::*; (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  logic signed [DIFF_BITS-1:0] dividend,
	input  wire  logic [RL_BITS-1:0]          divisor,
	output logic                             done,
	output logic signed [CUR_BITS-1:0]       quotient
);

	localparam int CNT_W = $clog2(DIFF_BITS + 1);

	logic [DIFF_BITS-1:0] mag_q;
	logic [RL_BITS-1:0]   rem_q;
	logic [RL_BITS-1:0]   dvs_q;
	logic                 neg_q;
	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [RL_BITS:0]     trial;
	logic                 fit;
	logic [DIFF_BITS-1:0] qfull;

	assign trial    = {rem_q, mag_q[DIFF_BITS-1]};
	assign fit      = trial >= {1'b0, dvs_q};
	assign qfull    = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign quotient = qfull[CUR_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvs_q  <= divisor;
				neg_q  <= dividend[DIFF_BITS-1];
				mag_q  <= dividend[DIFF_BITS-1] ? (~dividend + 1'b1) : dividend;
			end else if (busy_q) begin
				rem_q <= fit ? RL_BITS'(trial - {1'b0, dvs_q}) : trial[RL_BITS-1:0];
				mag_q <= {mag_q[DIFF_BITS-2:0], fit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIFF_BITS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/stereo_three_band_biquad_eq_top.sv =====
// mode 0 beat: steps each band's ramping coefficients, then filters every band for left
// and then right, then registers the result; commit beat with nonzero ramp length runs
// the one-bit-per-cycle divider for each of the 5 coefficients; other beats end on accept
// one item at a time through one shared multiplier; a result still held when the next
// sample finishes filtering stalls the sequencer until that result is taken
// arst_n clears control, ramp length to 480, coefficients to flat, memories to zero
`default_nettype none
module stereo_three_band_biquad_eq_top import beq_pkg::*; #(
	parameter int NUM_BANDS = NUM_BANDS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [87:0] s_tdata,  // left_in, right_in, band, coef_index, coef_value, zero pad
	input  wire  [2:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,  // left_out, right_out
	input  wire         cfg_we,
	input  wire  [11:0] cfg_wdata
);

	localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

	typedef enum logic [2:0] {ST_IDLE, ST_RAMP, ST_FILT, ST_DSTART, ST_DWAIT, ST_DONE} state_t;

	state_t state_q;

	logic [RL_BITS-1:0]               ramp_len_q;
	logic signed [GOAL_BITS-1:0]      goal_q [NUM_BANDS][NCOEF];
	logic signed [CUR_BITS-1:0]       cur_q  [NUM_BANDS][NCOEF];
	logic signed [CUR_BITS-1:0]       step_q [NUM_BANDS][NCOEF];
	logic [RL_BITS-1:0]               rl_q   [NUM_BANDS];
	logic signed [MEM_BITS-1:0]       z_q    [NUM_BANDS][2][2];

	logic [BW-1:0]                    bcnt_q;
	logic [CI_BITS-1:0]               jcnt_q;
	logic [2:0]                       k_q;
	logic                             ch_q;
	logic signed [SAMPLE_BITS-1:0]    x_q;
	logic signed [SAMPLE_BITS-1:0]    y_q;
	logic signed [SAMPLE_BITS-1:0]    rin_q;
	logic signed [SAMPLE_BITS-1:0]    lres_q;
	logic signed [ACC_BITS-1:0]       acc_q;
	logic signed [PSH_BITS-1:0]       acc2_q;
	logic                             ovalid_q;
	logic [47:0]                      odata_q;

	logic [MODE_BITS-1:0]             in_mode;
	logic signed [SAMPLE_BITS-1:0]    in_left;
	logic signed [SAMPLE_BITS-1:0]    in_right;
	logic [BAND_BITS-1:0]             in_band;
	logic [CI_BITS-1:0]               in_ci;
	logic signed [GOAL_BITS-1:0]      in_val;
	logic                             band_ok;
	logic [BW-1:0]                    in_bidx;

	logic [CI_BITS-1:0]               csel;
	logic signed [GOAL_BITS-1:0]      mul_a;
	logic signed [SAMPLE_BITS-1:0]    mul_b;
	logic signed [PROD_BITS-1:0]      prod;
	logic signed [PSH_BITS-1:0]       psh;
	logic signed [RND_BITS-1:0]       rnd;
	logic signed [SAMPLE_BITS-1:0]    ynew;

	logic                             div_start;
	logic                             div_done;
	logic signed [DIFF_BITS-1:0]      div_num;
	logic signed [CUR_BITS-1:0]       div_quo;
	logic signed [CUR_BITS-1:0]       goal_ext;

	assign in_mode  = s_tuser;
	assign in_left  = s_tdata[23:0];
	assign in_right = s_tdata[47:24];
	assign in_band  = s_tdata[49:48];
	assign in_ci    = s_tdata[52:50];
	assign in_val   = s_tdata[84:53];
	assign band_ok  = 32'(in_band) < NUM_BANDS;
	assign in_bidx  = BW'(in_band);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

	assign csel  = (k_q > CI_LAST) ? CI_LAST : k_q;
	assign mul_a = cur_q[bcnt_q][csel][CUR_BITS-1:EXT_BITS];
	assign mul_b = (k_q >= 3'd3) ? y_q : x_q;
	assign psh   = prod[PROD_BITS-1:PROD_SHIFT];
	assign rnd   = RND_BITS'(acc_q) + RND_BITS'(64'd1 << (OUT_SHIFT - 1));
	assign ynew  = sat_smp(rnd[RND_BITS-1:OUT_SHIFT]);

	assign goal_ext  = {goal_q[bcnt_q][jcnt_q], {EXT_BITS{1'b0}}};
	assign div_num   = DIFF_BITS'(goal_ext) - DIFF_BITS'(cur_q[bcnt_q][jcnt_q]);
	assign div_start = (state_q == ST_DSTART);

	beq_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	beq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (ramp_len_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ramp_len_q <= RL_BITS'(RL_RESET);
			ovalid_q   <= 1'b0;
			bcnt_q     <= '0;
			jcnt_q     <= '0;
			k_q        <= '0;
			ch_q       <= 1'b0;
			for (int b = 0; b < NUM_BANDS; b++) begin
				rl_q[b] <= '0;
				for (int j = 0; j < NCOEF; j++) begin
					goal_q[b][j] <= (j == 0) ? GOAL_ONE : '0;
					cur_q[b][j]  <= (j == 0) ? CUR_ONE : '0;
					step_q[b][j] <= '0;
				end
				for (int c = 0; c < 2; c++) begin
					z_q[b][c][0] <= '0;
					z_q[b][c][1] <= '0;
				end
			end
		end else begin
			if (cfg_we)
				ramp_len_q <= cfg_wdata;
			if (state_q == ST_DONE && (!ovalid_q || m_tready))
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (in_mode)
							MODE_SAMPLE: begin
								x_q    <= in_left;
								rin_q  <= in_right;
								bcnt_q <= '0;
								jcnt_q <= '0;
								k_q    <= '0;
								ch_q   <= 1'b0;
								state_q <= ST_RAMP;
							end
							MODE_STAGE: begin
								if (band_ok && in_ci <= CI_LAST)
									goal_q[in_bidx][in_ci] <= in_val;
							end
							MODE_COMMIT: begin
								if (band_ok) begin
									bcnt_q <= in_bidx;
									jcnt_q <= '0;
									if (ramp_len_q == '0) begin
										rl_q[in_bidx] <= '0;
										for (int j = 0; j < NCOEF; j++) begin
											cur_q[in_bidx][j]  <= {goal_q[in_bidx][j], {EXT_BITS{1'b0}}};
											step_q[in_bidx][j] <= '0;
										end
									end else begin
										state_q <= ST_DSTART;
									end
								end
							end
							MODE_CLEAR: begin
								for (int b = 0; b < NUM_BANDS; b++)
									for (int c = 0; c < 2; c++) begin
										z_q[b][c][0] <= '0;
										z_q[b][c][1] <= '0;
									end
							end
							MODE_FLAT: begin
								for (int b = 0; b < NUM_BANDS; b++) begin
									rl_q[b] <= '0;
									for (int j = 0; j < NCOEF; j++) begin
										goal_q[b][j] <= (j == 0) ? GOAL_ONE : '0;
										cur_q[b][j]  <= (j == 0) ? CUR_ONE : '0;
										step_q[b][j] <= '0;
									end
									for (int c = 0; c < 2; c++) begin
										z_q[b][c][0] <= '0;
										z_q[b][c][1] <= '0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RAMP: begin
					if (rl_q[bcnt_q] != '0) begin
						if (rl_q[bcnt_q] == RL_BITS'(1))
							cur_q[bcnt_q][jcnt_q] <= goal_ext;
						else
							cur_q[bcnt_q][jcnt_q] <= cur_q[bcnt_q][jcnt_q] + step_q[bcnt_q][jcnt_q];
					end
					if (jcnt_q == CI_LAST) begin
						jcnt_q <= '0;
						if (rl_q[bcnt_q] != '0)
							rl_q[bcnt_q] <= rl_q[bcnt_q] - 1'b1;
						if (bcnt_q == BW'(NUM_BANDS - 1)) begin
							bcnt_q  <= '0;
							state_q <= ST_FILT;
						end else begin
							bcnt_q <= bcnt_q + 1'b1;
						end
					end else begin
						jcnt_q <= jcnt_q + 1'b1;
					end
				end
				ST_FILT: begin
					k_q <= (k_q == 3'd5) ? 3'd0 : k_q + 1'b1;
					case (k_q)
						3'd1: acc_q <= ACC_BITS'(psh) + ACC_BITS'(z_q[bcnt_q][ch_q][0]);
						3'd2: begin
							y_q   <= ynew;
							acc_q <= ACC_BITS'(psh) + ACC_BITS'(z_q[bcnt_q][ch_q][1]);
						end
						3'd3: acc2_q <= psh;
						3'd4: z_q[bcnt_q][ch_q][0] <= sat_mem(acc_q - ACC_BITS'(psh));
						3'd5: begin
							z_q[bcnt_q][ch_q][1] <= sat_mem(ACC_BITS'(acc2_q) - ACC_BITS'(psh));
							if (bcnt_q == BW'(NUM_BANDS - 1)) begin
								bcnt_q <= '0;
								if (!ch_q) begin
									ch_q   <= 1'b1;
									lres_q <= y_q;
									x_q    <= rin_q;
								end else begin
									x_q     <= y_q;
									state_q <= ST_DONE;
								end
							end else begin
								x_q    <= y_q;
								bcnt_q <= bcnt_q + 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						step_q[bcnt_q][jcnt_q] <= div_quo;
						if (jcnt_q == CI_LAST) begin
							rl_q[bcnt_q] <= ramp_len_q;
							state_q      <= ST_IDLE;
						end else begin
							jcnt_q  <= jcnt_q + 1'b1;
							state_q <= ST_DSTART;
						end
					end
				end
				ST_DONE: begin
					if (!ovalid_q || m_tready) begin
						odata_q  <= {y_q, lres_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == MODE_SAMPLE) |=> !s_tready)
		else $error("sample beat did not start the sequencer");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the finishing state");

	a_filter_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILT) |-> (k_q <= 3'd5))
		else $error("filter step counter out of range");
`endif

endmodule
`default_nettype wire
